### hw/rtl/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg: indexed list engine shared types
// Request and response payloads, per-cell operation flags, request and
// status codes.
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam logic [2:0] FN_APPEND    = 3'd0;
    localparam logic [2:0] FN_PREPEND   = 3'd1;
    localparam logic [2:0] FN_INSERT_AT = 3'd2;
    localparam logic [2:0] FN_REMOVE_AT = 3'd3;
    localparam logic [2:0] FN_REMOVE_VL = 3'd4;
    localparam logic [2:0] FN_POP_FRONT = 3'd5;
    localparam logic [2:0] FN_POP_TAIL  = 3'd6;
    localparam logic [2:0] FN_READ_AT   = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam int POS_BITS = 5;

    typedef struct packed {
        logic [2:0]          func;
        logic [POS_BITS-1:0] position;
        logic [31:0]         entry_value;
        logic                free_request;
    } t_req;

    typedef struct packed {
        logic [31:0]         result_value;
        logic [POS_BITS-1:0] new_length;
        logic [1:0]          status;
        logic                release_res;
    } t_rsp;

    typedef struct packed {
        logic ins;
        logic rem_at;
        logic rem_val;
        logic rd;
    } t_cell_op;

endpackage

### hw/rtl/ilir_cell.sv
// ----------------------------------------------------------------------------
// ilir_cell: one list slot
// Holds one entry, opens a slot or closes a gap by taking a neighbor's entry,
// and passes the open, removed and tapped-value chains to the next slot.
// ----------------------------------------------------------------------------
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int IDX = 0,
    parameter int EW  = 32,
    parameter int PW  = 5,
    parameter int CW  = 5
) (
    input  logic          i_clk,
    input  t_cell_op      i_op,
    input  logic [PW-1:0] i_pos,
    input  logic [CW-1:0] i_cnt,
    input  logic [EW-1:0] i_val,
    input  logic [EW-1:0] i_left,
    input  logic [EW-1:0] i_right,
    input  logic          i_open,
    input  logic          i_seen,
    input  logic [EW-1:0] i_res,
    output logic [EW-1:0] o_entry,
    output logic          o_open,
    output logic          o_seen,
    output logic [EW-1:0] o_res
);

    logic [EW-1:0] r_entry;
    logic [EW-1:0] n_entry;
    logic          w_hit;
    logic          w_live;
    logic          w_kill;
    logic          w_open_here;
    logic          w_tap;

    assign w_hit       = (i_pos == PW'(IDX));
    assign w_live      = (PW'(IDX) < PW'(i_cnt));
    assign w_kill      = (i_op.rem_at && w_hit) ||
                         (i_op.rem_val && w_live && (r_entry == i_val) && !i_seen);
    assign w_open_here = i_op.ins && w_hit;
    assign w_tap       = w_kill || (i_op.rd && w_hit);

    assign o_seen  = i_seen || w_kill;
    assign o_open  = i_open || w_open_here;
    assign o_res   = i_res | (w_tap ? r_entry : '0);
    assign o_entry = r_entry;

    always_comb begin
        if (w_open_here) begin
            n_entry = i_val;
        end else if (i_open) begin
            n_entry = i_left;
        end else if (o_seen) begin
            n_entry = i_right;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### hw/rtl/indexed_list_insert_remove.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove: ordered list engine
// Keeps up to DEPTH entries in a row of slots with a length register.
//
// Request channel: i_in_valid / o_in_stall / i_in_data. One transaction is
// one request: append, prepend, insert at, remove at, remove by value, pop
// front, pop tail or read at. Response channel: o_out_valid / i_out_stall /
// o_out_data, one transaction per request, in request order.
// Configuration: i_cfg_valid / o_cfg_ready / i_cfg_data sets release_enabled;
// the port is always ready.
// Responses are registered. Throughput: one request per cycle while the
// response side does not stall; every request finishes in one pass through
// the slot row, where inserts shift right and removals shift left in the
// same cycle as the search and index compare.
// The request stage holds one request; while the response register holds an
// untaken response under stall, that request waits and o_in_stall rises.
// Reset empties the list and clears release_enabled; slot contents are not
// cleared, only slots below the length are ever read.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    localparam int EW = ENTRY_WIDTH;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

    logic          r_pend;
    t_req          r_req;
    logic          r_out_valid;
    t_rsp          r_out;
    t_rsp          n_out;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_rel_en;

    logic          w_exec;
    logic          w_accept;
    t_cell_op      w_op;
    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_cnt_x;
    logic [PW-1:0] w_req_pos;
    logic          w_full;
    logic          w_empty;
    logic [EW-1:0] w_val;
    logic [63:0]   w_res64;

    logic [EW-1:0] w_entry [DEPTH];
    logic          w_open  [DEPTH+1];
    logic          w_seen  [DEPTH+1];
    logic [EW-1:0] w_res   [DEPTH+1];

    assign w_exec     = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !w_exec;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_cnt_x   = PW'(r_cnt);
    assign w_req_pos = PW'(r_req.position);
    assign w_full    = (r_cnt == CW'(DEPTH));
    assign w_empty   = (r_cnt == '0);
    assign w_val     = EW'(64'(r_req.entry_value));

    assign w_open[0] = 1'b0;
    assign w_seen[0] = 1'b0;
    assign w_res[0]  = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [EW-1:0] w_left;
        logic [EW-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end
        ilir_cell #(
            .IDX (g),
            .EW  (EW),
            .PW  (PW),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_pos   (w_pos),
            .i_cnt   (r_cnt),
            .i_val   (w_val),
            .i_left  (w_left),
            .i_right (w_right),
            .i_open  (w_open[g]),
            .i_seen  (w_seen[g]),
            .i_res   (w_res[g]),
            .o_entry (w_entry[g]),
            .o_open  (w_open[g+1]),
            .o_seen  (w_seen[g+1]),
            .o_res   (w_res[g+1])
        );
    end

    assign w_res64 = 64'(w_res[DEPTH]);

    always_comb begin
        w_op  = '0;
        w_pos = w_req_pos;
        n_out = '0;
        case (r_req.func)
            FN_APPEND: begin
                if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_op.ins = 1'b1;
                    w_pos    = w_cnt_x;
                end
            end
            FN_PREPEND: begin
                if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_op.ins = 1'b1;
                    w_pos    = '0;
                end
            end
            FN_INSERT_AT: begin
                if (w_req_pos > w_cnt_x) begin
                    n_out.status = ST_RANGE;
                end else if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_op.ins = 1'b1;
                end
            end
            FN_REMOVE_AT: begin
                if (w_req_pos >= w_cnt_x) begin
                    n_out.status = ST_RANGE;
                end else begin
                    w_op.rem_at       = 1'b1;
                    n_out.release_res = r_req.free_request && r_rel_en;
                end
            end
            FN_REMOVE_VL: begin
                if (w_empty) begin
                    n_out.status = ST_RANGE;
                end else begin
                    w_op.rem_val      = 1'b1;
                    n_out.status      = w_seen[DEPTH] ? ST_OK : ST_MISSING;
                    n_out.release_res = w_seen[DEPTH] && r_req.free_request && r_rel_en;
                end
            end
            FN_POP_FRONT: begin
                if (w_empty) begin
                    n_out.status = ST_RANGE;
                end else begin
                    w_op.rem_at = 1'b1;
                    w_pos       = '0;
                end
            end
            FN_POP_TAIL: begin
                if (w_empty) begin
                    n_out.status = ST_RANGE;
                end else begin
                    w_op.rem_at = 1'b1;
                    w_pos       = w_cnt_x - PW'(1);
                end
            end
            FN_READ_AT: begin
                if (w_req_pos >= w_cnt_x) begin
                    n_out.status = ST_RANGE;
                end else begin
                    w_op.rd = 1'b1;
                end
            end
            default: begin
                n_out.status = ST_RANGE;
            end
        endcase
        if (!w_exec) begin
            w_op = '0;
        end
        n_cnt = r_cnt;
        if (w_op.ins) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_op.rem_at || (w_op.rem_val && w_seen[DEPTH])) begin
            n_cnt = r_cnt - CW'(1);
        end
        n_out.result_value = w_res64[31:0];
        n_out.new_length   = POS_BITS'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_rel_en    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_exec) begin
                r_pend <= 1'b0;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
                r_cnt       <= n_cnt;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_rel_en <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
        if (w_exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

### hw/rtl/ilir_checker.sv
// ----------------------------------------------------------------------------
// ilir_checker: port-level checks for the list engine
// Watches the response channel for held transactions, reset behavior and
// consistency of status, release flag and result value.
// ----------------------------------------------------------------------------
module ilir_checker
    import ilir_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_req i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_rsp o_out_data,
    input logic i_cfg_valid,
    input logic o_cfg_ready,
    input logic i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("response changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid right after reset");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |->
            (o_out_data.result_value == '0) && !o_out_data.release_res)
        else $error("failed request carries a value or release");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_FULL) |->
            (o_out_data.new_length != '0))
        else $error("full status with empty list");

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (.*);

### tb/indexed_list_insert_remove_test.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_test: ordered list engine testbench
// Drives request transactions from a backlog queue and predicts each
// response with a queue-based list model. Responses are checked field by
// field in order. Both channels idle at random, and the response side holds
// off for long stretches so that the request side backs up. Runs a directed
// pass over empty, full and range cases, then random passes with release
// enabled and disabled.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_test;
    import ilir_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 425;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_req i_in_data   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_data  = 1'b0;

    logic        hold_off   = 1'b0;
    logic        release_en = 1'b0;
    logic [31:0] list_q[$];
    t_req        req_backlog[$];
    int          gap_backlog[$];
    t_rsp        due_rsp[$];
    int          accepted   = 0;
    int          mismatches = 0;
    int          stall_left = 0;
    int          quiet_left = 0;

    logic [2:0] put_fns[3]  = '{FN_APPEND, FN_PREPEND, FN_INSERT_AT};
    logic [2:0] take_fns[5] = '{FN_REMOVE_AT, FN_REMOVE_VL, FN_POP_FRONT,
                                FN_POP_TAIL, FN_READ_AT};

    indexed_list_insert_remove u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_rsp apply_request(input t_req r);
        t_rsp s;
        int   pos;
        int   len;
        int   hit;
        s   = '0;
        pos = int'(r.position);
        len = list_q.size();
        s.status = ST_OK;
        case (r.func)
            FN_APPEND: begin
                if (len >= LIST_DEPTH) s.status = ST_FULL;
                else list_q.push_back(r.entry_value);
            end
            FN_PREPEND: begin
                if (len >= LIST_DEPTH) s.status = ST_FULL;
                else list_q.push_front(r.entry_value);
            end
            FN_INSERT_AT: begin
                if (pos > len) s.status = ST_RANGE;
                else if (len >= LIST_DEPTH) s.status = ST_FULL;
                else list_q.insert(pos, r.entry_value);
            end
            FN_REMOVE_AT: begin
                if (pos >= len) begin
                    s.status = ST_RANGE;
                end else begin
                    s.result_value = list_q[pos];
                    list_q.delete(pos);
                    s.release_res = r.free_request & release_en;
                end
            end
            FN_REMOVE_VL: begin
                if (len == 0) begin
                    s.status = ST_RANGE;
                end else begin
                    hit = -1;
                    for (int i = 0; i < len; i++) begin
                        if (hit < 0 && list_q[i] == r.entry_value) hit = i;
                    end
                    if (hit < 0) begin
                        s.status = ST_MISSING;
                    end else begin
                        s.result_value = list_q[hit];
                        list_q.delete(hit);
                        s.release_res = r.free_request & release_en;
                    end
                end
            end
            FN_POP_FRONT: begin
                if (len == 0) s.status = ST_RANGE;
                else s.result_value = list_q.pop_front();
            end
            FN_POP_TAIL: begin
                if (len == 0) s.status = ST_RANGE;
                else s.result_value = list_q.pop_back();
            end
            default: begin
                if (pos >= len) s.status = ST_RANGE;
                else s.result_value = list_q[pos];
            end
        endcase
        s.new_length = POS_BITS'(list_q.size());
        return s;
    endfunction

    function automatic int pick_gap(input bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (!busy || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return $urandom_range(0, 7);
        if (r < 75) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic push_req(input logic [2:0] f, input int p, input logic [31:0] v,
                            input logic fr, input bit busy);
        t_req q;
        q.func         = f;
        q.position     = POS_BITS'(p);
        q.entry_value  = v;
        q.free_request = fr;
        req_backlog.push_back(q);
        gap_backlog.push_back(pick_gap(busy));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic write_release(input logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        release_en = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || i_in_valid || due_rsp.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : req_driver
        t_req nxt;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                due_rsp.push_back(apply_request(i_in_data));
                accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (req_backlog.size() != 0 && gap_backlog[0] == 0) begin
                    nxt = req_backlog.pop_front();
                    void'(gap_backlog.pop_front());
                    i_in_valid <= 1'b1;
                    i_in_data  <= nxt;
                end else begin
                    if (gap_backlog.size() != 0) gap_backlog[0] = gap_backlog[0] - 1;
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        int   pick;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_rsp.size() == 0) begin
                    report_mismatch("response with none due", o_out_data.result_value, 0);
                end else begin
                    want = due_rsp.pop_front();
                    if (o_out_data.result_value !== want.result_value)
                        report_mismatch("result_value", o_out_data.result_value,
                                        want.result_value);
                    if (o_out_data.new_length !== want.new_length)
                        report_mismatch("new_length", 32'(o_out_data.new_length),
                                        32'(want.new_length));
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", 32'(o_out_data.status),
                                        32'(want.status));
                    if (o_out_data.release_res !== want.release_res)
                        report_mismatch("release_res", 32'(o_out_data.release_res),
                                        32'(want.release_res));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (quiet_left > 0) begin
                quiet_left--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) stall_left = $urandom_range(1, 3);
                else if (pick < 52) stall_left = $urandom_range(8, 40);
                else quiet_left = $urandom_range(0, 30);
            end
            i_out_stall <= hold_off || (stall_left > 0);
        end
    end

    // hold the response side off while requests keep coming
    initial begin : backpressure
        for (int n = 1; n <= 2; n++) begin
            do @(negedge i_clk); while (accepted < n * 500);
            @(posedge i_clk);
            hold_off <= 1'b1;
            repeat (60) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int  bias;
        int  r;
        bit  busy;
        logic [2:0] f;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_release(1'b1);
        @(negedge i_clk);

        push_req(FN_POP_FRONT, 0, 0, 1'b1, 1);
        push_req(FN_POP_TAIL, 0, 0, 1'b1, 1);
        push_req(FN_REMOVE_VL, 0, 0, 1'b1, 1);
        push_req(FN_READ_AT, 16, 0, 1'b0, 1);
        push_req(FN_INSERT_AT, 1, 32'h1, 1'b0, 1);
        push_req(FN_INSERT_AT, 0, 32'hFFFF_FFFF, 1'b0, 1);
        for (int k = 1; k < LIST_DEPTH; k++) begin
            if (k == 5) push_req(FN_PREPEND, 0, 32'h0, 1'b0, 1);
            else if (k == 9) push_req(FN_INSERT_AT, 4, 32'h8000_0001, 1'b0, 1);
            else push_req(FN_APPEND, 0, 32'(k) * 32'h1111_1111, 1'b0, 1);
        end
        push_req(FN_APPEND, 0, 32'h5, 1'b0, 1);
        push_req(FN_INSERT_AT, 16, 32'h6, 1'b0, 1);
        push_req(FN_REMOVE_VL, 0, 32'hFFFF_FFFF, 1'b1, 1);
        push_req(FN_REMOVE_AT, 16, 0, 1'b1, 1);
        push_req(FN_POP_TAIL, 0, 0, 1'b1, 1);
        push_req(FN_POP_FRONT, 0, 0, 1'b1, 1);
        push_req(FN_REMOVE_VL, 0, 32'h1234_5678, 1'b1, 1);

        bias = 50;
        busy = 1;
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            write_release(p[0]);
            @(negedge i_clk);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 25 == 0) begin
                    case ($urandom_range(0, 2))
                        0: bias = 20;
                        1: bias = 50;
                        default: bias = 80;
                    endcase
                    busy = ($urandom_range(0, 9) < 7);
                end
                r = $urandom_range(0, 99);
                if (r < bias) f = put_fns[$urandom_range(0, 2)];
                else f = take_fns[$urandom_range(0, 4)];
                r = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4) : $urandom_range(0, 16);
                push_req(f, r, pick_value(), 1'($urandom_range(0, 1)), busy);
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### indexed_list_insert_remove.f
hw/rtl/ilir_pkg.sv
hw/rtl/ilir_cell.sv
hw/rtl/indexed_list_insert_remove.sv
hw/rtl/ilir_checker.sv
tb/indexed_list_insert_remove_test.sv
